// ----- design/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Opcodes, status codes and pipeline control types of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_RECIP = 3'd4;
    localparam logic [2:0] OP_SQR   = 3'd5;
    localparam logic [2:0] OP_CONJ  = 3'd6;
    localparam logic [2:0] OP_NEG   = 3'd7;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV
    } cls_t;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        cls_t cls;
        logic ovf;
        logic neg_re;
        logic neg_im;
        logic dz;
    } ctl_t;

endpackage

// ----- design/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Four-stage front end: operand remap and simple ops, products, sums,
// then multiply saturation and sign/magnitude split of the quotient terms.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0]                    opcode,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output cau_pkg::ctl_t                 ctl,
    output logic [DATA_WIDTH-1:0]         sres_re,
    output logic [DATA_WIDTH-1:0]         sres_im,
    output logic [2*DATA_WIDTH-1:0]       num_re,
    output logic [2*DATA_WIDTH-1:0]       num_im,
    output logic [2*DATA_WIDTH-1:0]       den
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

    // ---------------- stage 1 ----------------
    logic                valid1_reg;
    cau_pkg::cls_t       cls1_reg, cls1_next;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [W-1:0] ar1_next, ai1_next, br1_next, bi1_next;
    logic [W-1:0]        sre1_reg, sim1_reg, sre1_next, sim1_next;
    logic                sovf1_reg, sovf1_next;
    logic signed [W:0]   xa_re, xa_im, xb_re, xb_im, v_re, v_im;

    assign xa_re = {a_re[W-1], a_re};
    assign xa_im = {a_im[W-1], a_im};
    assign xb_re = {b_re[W-1], b_re};
    assign xb_im = {b_im[W-1], b_im};

    always_comb
    begin
        cls1_next = cau_pkg::CLS_SIMPLE;
        ar1_next  = a_re;
        ai1_next  = a_im;
        br1_next  = b_re;
        bi1_next  = b_im;
        v_re      = xa_re;
        v_im      = xa_im;
        unique case (opcode)
            cau_pkg::OP_ADD:
            begin
                v_re = xa_re + xb_re;
                v_im = xa_im + xb_im;
            end
            cau_pkg::OP_SUB:
            begin
                v_re = xa_re - xb_re;
                v_im = xa_im - xb_im;
            end
            cau_pkg::OP_MUL:
            begin
                cls1_next = cau_pkg::CLS_MUL;
            end
            cau_pkg::OP_DIV:
            begin
                cls1_next = cau_pkg::CLS_DIV;
            end
            cau_pkg::OP_RECIP:
            begin
                cls1_next = cau_pkg::CLS_DIV;
                ar1_next  = ONE;
                ai1_next  = '0;
                br1_next  = a_re;
                bi1_next  = a_im;
            end
            cau_pkg::OP_SQR:
            begin
                cls1_next = cau_pkg::CLS_MUL;
                br1_next  = a_re;
                bi1_next  = a_im;
            end
            cau_pkg::OP_CONJ:
            begin
                v_im = -xa_im;
            end
            cau_pkg::OP_NEG:
            begin
                v_re = -xa_re;
                v_im = -xa_im;
            end
            default:
            begin
                cls1_next = cau_pkg::CLS_SIMPLE;
            end
        endcase
        // overflow when the two top bits disagree
        sre1_next  = (v_re[W] ^ v_re[W-1]) ? (v_re[W] ? MINV : MAXV) : v_re[W-1:0];
        sim1_next  = (v_im[W] ^ v_im[W-1]) ? (v_im[W] ? MINV : MAXV) : v_im[W-1:0];
        sovf1_next = (v_re[W] ^ v_re[W-1]) | (v_im[W] ^ v_im[W-1]);
    end

    // ---------------- stage 2: products ----------------
    logic                 valid2_reg;
    cau_pkg::cls_t        cls2_reg;
    logic [W-1:0]         sre2_reg, sim2_reg;
    logic                 sovf2_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_br_reg, p_bi_reg;

    // ---------------- stage 3: sums ----------------
    logic               valid3_reg;
    cau_pkg::cls_t      cls3_reg;
    logic [W-1:0]       sre3_reg, sim3_reg;
    logic               sovf3_reg;
    logic signed [PW:0] mre3_reg, mim3_reg, nre3_reg, nim3_reg;
    logic signed [PW:0] mre3_next, mim3_next, nre3_next, nim3_next;
    logic [PW-1:0]      den3_reg, den3_next;
    logic signed [PW:0] x_rr, x_ii, x_ri, x_ir;

    assign x_rr = {p_rr_reg[PW-1], p_rr_reg};
    assign x_ii = {p_ii_reg[PW-1], p_ii_reg};
    assign x_ri = {p_ri_reg[PW-1], p_ri_reg};
    assign x_ir = {p_ir_reg[PW-1], p_ir_reg};

    always_comb
    begin
        mre3_next = x_rr - x_ii;
        mim3_next = x_ri + x_ir;
        nre3_next = x_rr + x_ii;
        nim3_next = x_ir - x_ri;
        den3_next = p_br_reg + p_bi_reg;
    end

    // ---------------- stage 4 ----------------
    cau_pkg::ctl_t      ctl4_reg, ctl4_next;
    logic [W-1:0]       sre4_reg, sim4_reg, sre4_next, sim4_next;
    logic [PW-1:0]      nre4_reg, nim4_reg, nre4_next, nim4_next;
    logic [PW-1:0]      den4_reg;
    logic signed [PW:0] sh_re, sh_im, mag_re, mag_im;
    logic               mo_re, mo_im;

    always_comb
    begin
        sh_re  = mre3_reg >>> FRAC_BITS;
        sh_im  = mim3_reg >>> FRAC_BITS;
        mo_re  = !((&sh_re[PW:W-1]) || (~|sh_re[PW:W-1]));
        mo_im  = !((&sh_im[PW:W-1]) || (~|sh_im[PW:W-1]));
        mag_re = nre3_reg[PW] ? -nre3_reg : nre3_reg;
        mag_im = nim3_reg[PW] ? -nim3_reg : nim3_reg;
        nre4_next = mag_re[PW-1:0];
        nim4_next = mag_im[PW-1:0];

        ctl4_next.valid  = valid3_reg;
        ctl4_next.cls    = cls3_reg;
        ctl4_next.neg_re = nre3_reg[PW];
        ctl4_next.neg_im = nim3_reg[PW];
        ctl4_next.dz     = (den3_reg == '0);
        if (cls3_reg == cau_pkg::CLS_MUL)
        begin
            sre4_next     = mo_re ? (sh_re[PW] ? MINV : MAXV) : sh_re[W-1:0];
            sim4_next     = mo_im ? (sh_im[PW] ? MINV : MAXV) : sh_im[W-1:0];
            ctl4_next.ovf = mo_re | mo_im;
        end
        else
        begin
            sre4_next     = sre3_reg;
            sim4_next     = sim3_reg;
            ctl4_next.ovf = sovf3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            ctl4_reg   <= '0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            ctl4_reg   <= ctl4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls1_reg  <= cls1_next;
            ar1_reg   <= ar1_next;
            ai1_reg   <= ai1_next;
            br1_reg   <= br1_next;
            bi1_reg   <= bi1_next;
            sre1_reg  <= sre1_next;
            sim1_reg  <= sim1_next;
            sovf1_reg <= sovf1_next;

            cls2_reg  <= cls1_reg;
            sre2_reg  <= sre1_reg;
            sim2_reg  <= sim1_reg;
            sovf2_reg <= sovf1_reg;
            p_rr_reg  <= ar1_reg * br1_reg;
            p_ii_reg  <= ai1_reg * bi1_reg;
            p_ri_reg  <= ar1_reg * bi1_reg;
            p_ir_reg  <= ai1_reg * br1_reg;
            p_br_reg  <= br1_reg * br1_reg;
            p_bi_reg  <= bi1_reg * bi1_reg;

            cls3_reg  <= cls2_reg;
            sre3_reg  <= sre2_reg;
            sim3_reg  <= sim2_reg;
            sovf3_reg <= sovf2_reg;
            mre3_reg  <= mre3_next;
            mim3_reg  <= mim3_next;
            nre3_reg  <= nre3_next;
            nim3_reg  <= nim3_next;
            den3_reg  <= den3_next;

            sre4_reg  <= sre4_next;
            sim4_reg  <= sim4_next;
            nre4_reg  <= nre4_next;
            nim4_reg  <= nim4_next;
            den4_reg  <= den3_reg;
        end
    end

    assign ctl     = ctl4_reg;
    assign sres_re = sre4_reg;
    assign sres_im = sim4_reg;
    assign num_re  = nre4_reg;
    assign num_im  = nim4_reg;
    assign den     = den4_reg;

endmodule

// ----- design/cau_div_lane.sv -----
// ----------------------------------------------------------------------------
// cau_div_lane
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage. A range stage flags quotients of 2^(DATA_WIDTH+1) or more.
// ----------------------------------------------------------------------------
module cau_div_lane #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [2*DATA_WIDTH-1:0] num,
    input  logic [2*DATA_WIDTH-1:0] den,
    output logic [DATA_WIDTH:0]     quo,
    output logic                    big
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + FRAC_BITS;
    localparam int HW = DATA_WIDTH + FRAC_BITS - 1;
    localparam int CW = (HW > RW) ? HW : RW;
    localparam int NS = DATA_WIDTH + 1;

    logic [SW-1:0] scaled;
    logic [HW-1:0] hi;

    assign scaled = SW'(num) << FRAC_BITS;
    assign hi     = scaled[SW-1:W+1];

    logic [RW-1:0] rem_reg [0:NS];
    logic [W:0]    nb_reg  [0:NS];
    logic [W:0]    q_reg   [0:NS];
    logic [RW-1:0] den_reg [0:NS];
    logic          big_reg [0:NS];

    // range check and initial partial remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg[0] <= CW'(hi) >= CW'(den);
            rem_reg[0] <= RW'(hi);
            nb_reg[0]  <= scaled[W:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        logic [RW:0] r2, diff;
        logic        ge;

        always_comb
        begin
            r2   = {rem_reg[k-1], nb_reg[k-1][W]};
            diff = r2 - {1'b0, den_reg[k-1]};
            ge   = r2 >= {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[RW-1:0] : r2[RW-1:0];
                nb_reg[k]  <= nb_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][W-1:0], ge};
                den_reg[k] <= den_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quo = q_reg[NS];
    assign big = big_reg[NS];

endmodule

// ----- design/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed-point operand pairs with saturation.
//
//   channel | valid     | stall      | payload
//   --------+-----------+------------+---------------------------------
//   input   | in_valid  | in_stall   | opcode, a_re, a_im, b_re, b_im
//   output  | out_valid | out_stall  | res_re, res_im, status
//
// One item per cycle unless a result waits under out_stall. The divider,
// one quotient bit per stage, sits behind a four-stage front end.
// Reset clears the valid and control bits only; the pipeline holds while a
// result waits under out_stall, and keeps taking items into empty slots otherwise.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   opcode,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic [1:0]                   status
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * DATA_WIDTH;
    localparam int LAT = DATA_WIDTH + 2;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]   HALF = {2'b01, {(W-1){1'b0}}};

    logic adv;

    logic               out_valid_reg;
    logic [W-1:0]       res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic [1:0]         status_reg, status_next;

    cau_pkg::ctl_t      f_ctl;
    logic [W-1:0]       f_sre, f_sim;
    logic [PW-1:0]      f_nre, f_nim, f_den;
    logic [W:0]         q_re, q_im;
    logic               big_re, big_im;

    // hold everything while a finished result is stalled
    assign in_stall = out_valid_reg & out_stall;
    assign adv      = ~in_stall;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (in_valid),
        .opcode   (opcode),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .ctl      (f_ctl),
        .sres_re  (f_sre),
        .sres_im  (f_sim),
        .num_re   (f_nre),
        .num_im   (f_nim),
        .den      (f_den)
    );

    cau_div_lane #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_re (
        .clk (clk),
        .en  (adv),
        .num (f_nre),
        .den (f_den),
        .quo (q_re),
        .big (big_re)
    );

    cau_div_lane #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_im (
        .clk (clk),
        .en  (adv),
        .num (f_nim),
        .den (f_den),
        .quo (q_im),
        .big (big_im)
    );

    // side line matching the divider depth
    cau_pkg::ctl_t sb_ctl_reg [0:LAT-1];
    logic [W-1:0]  sb_re_reg  [0:LAT-1];
    logic [W-1:0]  sb_im_reg  [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                sb_ctl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            sb_ctl_reg[0] <= f_ctl;
            for (int i = 1; i < LAT; i++)
            begin
                sb_ctl_reg[i] <= sb_ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_re_reg[0] <= f_sre;
            sb_im_reg[0] <= f_sim;
            for (int i = 1; i < LAT; i++)
            begin
                sb_re_reg[i] <= sb_re_reg[i-1];
                sb_im_reg[i] <= sb_im_reg[i-1];
            end
        end
    end

    // saturate a quotient magnitude under its sign: {overflow, value}
    function automatic logic [W:0] quot_sat(input logic [W:0] q, input logic bg,
                                            input logic neg);
        logic         ov;
        logic [W:0]   nq;
        logic [W-1:0] val;
        begin
            nq = -q;
            if (neg)
            begin
                ov  = bg | (q > HALF);
                val = ov ? MINV : nq[W-1:0];
            end
            else
            begin
                ov  = bg | (q >= HALF);
                val = ov ? MAXV : q[W-1:0];
            end
            quot_sat = {ov, val};
        end
    endfunction

    logic [W:0]    qs_re, qs_im;
    cau_pkg::ctl_t last;

    always_comb
    begin
        last  = sb_ctl_reg[LAT-1];
        qs_re = quot_sat(q_re, big_re, last.neg_re);
        qs_im = quot_sat(q_im, big_im, last.neg_im);
        if (last.cls == cau_pkg::CLS_DIV)
        begin
            if (last.dz)
            begin
                res_re_next = MAXV;
                res_im_next = MAXV;
                status_next = cau_pkg::ST_DZ;
            end
            else
            begin
                res_re_next = qs_re[W-1:0];
                res_im_next = qs_im[W-1:0];
                status_next = (qs_re[W] | qs_im[W]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            end
        end
        else
        begin
            res_re_next = sb_re_reg[LAT-1];
            res_im_next = sb_im_reg[LAT-1];
            status_next = last.ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_dz_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == cau_pkg::ST_DZ
            |-> res_re_reg == MAXV && res_im_reg == MAXV)
        else $error("division by zero result not saturated");

    a_last_stage_drains : assert property (@(posedge clk) disable iff (!rst_n)
        sb_ctl_reg[LAT-1].valid && adv |=> out_valid_reg)
        else $error("item lost between divider and output register");

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> status_reg == cau_pkg::ST_OK || status_reg == cau_pkg::ST_OVF
            || status_reg == cau_pkg::ST_DZ)
        else $error("undefined status code");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex ALU: a directed table covering operand
// extremes, every opcode, division by zero and saturation, then random
// operations checked against an in-bench model of the fixed-point math, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int  FRAC    = 16;
    localparam int  N_RAND  = 1300;
    localparam int  LATENCY = 39;
    localparam longint MAX_CYCLES = 400000;

    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] ar, ai, br, bi;
        logic               known;
        logic signed [31:0] rr, ri;
        logic [1:0]         st;
    } vec_t;

    typedef struct {
        logic signed [31:0] rr, ri;
        logic [1:0]         st;
    } res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic signed [31:0] a_re, a_im, b_re, b_im;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] res_re, res_im;
    logic [1:0]         status;

    res_t   pending_results[$];
    int     errors;
    longint cycle;
    bit     hold_req;
    bit     quiet_out;
    bit     quiet_in;

    complex_arithmetic_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [31:0] sat32(input logic signed [127:0] v,
                                                 inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return SMAX;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return SMIN;
        end
        return v[31:0];
    endfunction

    // quotient of (num << FRAC) / den, truncated toward zero; den positive
    function automatic logic signed [127:0] fx_quot(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FRAC) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic res_t alu_result(input logic [2:0] op,
                                        input logic signed [31:0] ar_i,
                                        input logic signed [31:0] ai_i,
                                        input logic signed [31:0] br_i,
                                        input logic signed [31:0] bi_i);
        logic signed [127:0] ar, ai, br, bi, vr, vi, m;
        logic [2:0] kind;
        logic ovf;
        res_t r;
        ar = ar_i; ai = ai_i; br = br_i; bi = bi_i;
        kind = op;
        ovf = 1'b0;
        if (op == cau_pkg::OP_RECIP)
        begin
            br = ar; bi = ai; ar = 128'sd1 <<< FRAC; ai = 0; kind = cau_pkg::OP_DIV;
        end
        else if (op == cau_pkg::OP_SQR)
        begin
            br = ar; bi = ai; kind = cau_pkg::OP_MUL;
        end
        case (kind)
            cau_pkg::OP_ADD: begin vr = ar + br; vi = ai + bi; end
            cau_pkg::OP_SUB: begin vr = ar - br; vi = ai - bi; end
            cau_pkg::OP_MUL:
            begin
                vr = (ar * br - ai * bi) >>> FRAC;
                vi = (ar * bi + ai * br) >>> FRAC;
            end
            cau_pkg::OP_DIV:
            begin
                m = br * br + bi * bi;
                if (m == 0)
                begin
                    r.rr = SMAX; r.ri = SMAX; r.st = cau_pkg::ST_DZ;
                    return r;
                end
                vr = fx_quot(ar * br + ai * bi, m);
                vi = fx_quot(ai * br - ar * bi, m);
            end
            cau_pkg::OP_CONJ: begin vr = ar; vi = -ai; end
            default: begin vr = -ar; vi = -ai; end
        endcase
        r.rr = sat32(vr, ovf);
        r.ri = sat32(vi, ovf);
        r.st = ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at cycle %0d: got %h, expected %h", what, cycle, got, want);
        errors++;
    endtask

    function automatic logic signed [31:0] rnd_operand();
        case ($urandom_range(0, 9))
            0: return SMAX;
            1: return SMIN;
            2: return 0;
            3: return $signed($urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000);
            4, 5: return $signed(32'($urandom_range(0, 32'h0003_ffff)) -
                                 32'h0001_ffff);
            6, 7: return $signed(32'($urandom_range(0, 32'h00ff_ffff)) -
                                 32'h007f_ffff);
            default: return $signed($urandom);
        endcase
    endfunction

    // one transfer on the input channel
    task automatic send(input vec_t v);
        res_t want;
        while (!quiet_in && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= v.op;
        a_re     <= v.ar;
        a_im     <= v.ai;
        b_re     <= v.br;
        b_im     <= v.bi;
        want = alu_result(v.op, v.ar, v.ai, v.br, v.bi);
        if (v.known)
        begin
            want.rr = v.rr; want.ri = v.ri; want.st = v.st;
        end
        do @(posedge clk); while (in_stall);
        pending_results.push_back(want);
    endtask

    function automatic vec_t row(input logic [2:0] op, input logic signed [31:0] ar,
                                 input logic signed [31:0] ai,
                                 input logic signed [31:0] br,
                                 input logic signed [31:0] bi, input logic known,
                                 input logic signed [31:0] rr,
                                 input logic signed [31:0] ri, input logic [1:0] st);
        vec_t v;
        v.op = op; v.ar = ar; v.ai = ai; v.br = br; v.bi = bi;
        v.known = known; v.rr = rr; v.ri = ri; v.st = st;
        return v;
    endfunction

    // output side: random stall, with a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= !quiet_out && ($urandom_range(0, 99) < 13);
        end
    end

    // compare each transfer on the output channel
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle);
                errors++;
            end
            else
            begin
                res_t want;
                want = pending_results.pop_front();
                if (res_re !== want.rr) report_mismatch("res_re", res_re, want.rr);
                if (res_im !== want.ri) report_mismatch("res_im", res_im, want.ri);
                if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES)
        begin
            $display("FAIL complex_arithmetic_unit");
            $finish;
        end
    end

    initial
    begin
        vec_t dir[$];
        vec_t v;
        int   idle;
        cycle     = 0;
        errors    = 0;
        hold_req  = 1'b0;
        quiet_out = 1'b0;
        quiet_in  = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = cau_pkg::OP_ADD;
        a_re = 0; a_im = 0; b_re = 0; b_im = 0;

        dir.push_back(row(cau_pkg::OP_ADD, SMAX, SMIN, SMAX, SMIN,
                          1, SMAX, SMIN, cau_pkg::ST_OVF));
        dir.push_back(row(cau_pkg::OP_ADD, 1, -1, 2, 3, 1, 3, 2, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_SUB, 0, 5, SMIN, 5, 1, SMAX, 0, cau_pkg::ST_OVF));
        dir.push_back(row(cau_pkg::OP_SUB, SMIN, SMAX, SMAX, SMIN,
                          1, SMIN, SMAX, cau_pkg::ST_OVF));
        dir.push_back(row(cau_pkg::OP_MUL, 32'sh10000, 32'sh20000, 32'sh30000, 32'sh10000,
                          1, 32'sh10000, 32'sh70000, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_MUL, SMAX, SMAX, SMAX, SMIN, 0, 0, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_MUL, -1, 0, 1, 0, 1, -1, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_DIV, 32'sh10000, 0, 0, 0,
                          1, SMAX, SMAX, cau_pkg::ST_DZ));
        dir.push_back(row(cau_pkg::OP_DIV, 32'sh40000, 32'sh20000, 32'sh20000, 0,
                          1, 32'sh20000, 32'sh10000, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_DIV, SMAX, SMIN, 1, 0,
                          1, SMAX, SMIN, cau_pkg::ST_OVF));
        dir.push_back(row(cau_pkg::OP_DIV, -3, 0, 32'sh20000, 0,
                          1, -1, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_DIV, SMIN, SMAX, SMIN, SMIN, 0, 0, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_RECIP, 0, 0, 7, 7, 1, SMAX, SMAX, cau_pkg::ST_DZ));
        dir.push_back(row(cau_pkg::OP_RECIP, 32'sh20000, 0, 0, 0,
                          1, 32'sh8000, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_RECIP, 1, 1, 0, 0, 0, 0, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_RECIP, SMIN, SMAX, 0, 0, 0, 0, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_SQR, 32'sh10000, 32'sh10000, 0, 0,
                          1, 0, 32'sh20000, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_SQR, SMIN, SMIN, 0, 0, 0, 0, 0, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_CONJ, SMIN, SMIN, 0, 0,
                          1, SMIN, SMAX, cau_pkg::ST_OVF));
        dir.push_back(row(cau_pkg::OP_CONJ, SMAX, SMAX, 0, 0,
                          1, SMAX, -SMAX, cau_pkg::ST_OK));
        dir.push_back(row(cau_pkg::OP_NEG, SMIN, 3, 0, 0, 1, SMAX, -3, cau_pkg::ST_OVF));
        dir.push_back(row(cau_pkg::OP_NEG, SMAX, -1, -1, -1,
                          1, -SMAX, 1, cau_pkg::ST_OK));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i]) send(dir[i]);

        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == 300) hold_req = 1'b1;
            quiet_in  = (n >= 600 && n < 800);
            quiet_out = quiet_in;
            v.op = 3'($urandom_range(0, 7));
            v.ar = rnd_operand();
            v.ai = rnd_operand();
            v.br = rnd_operand();
            v.bi = rnd_operand();
            if ($urandom_range(0, 19) == 0)
            begin
                v.br = 0; v.bi = 0;
            end
            v.known = 1'b0;
            send(v);
        end
        in_valid <= 1'b0;

        idle = 0;
        while (pending_results.size() != 0 && idle < 20000)
        begin
            @(posedge clk);
            idle++;
        end
        repeat (2 * LATENCY) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("PASS complex_arithmetic_unit");
        else
            $display("FAIL complex_arithmetic_unit");
        $finish;
    end

endmodule
